>>> hw/rtl/rsts_pkg.sv
// Shared types, constants and helpers of the receive sequence tracker.
package rsts_pkg;

  localparam int SEQ_SPACE  = 65536;
  localparam int SEQ_W      = 16;
  localparam int SEQ_IDX_W  = $clog2(SEQ_SPACE);
  localparam int ROW_W      = 64;
  localparam int ROW_BIT_W  = $clog2(ROW_W);
  localparam int ROWS       = SEQ_SPACE / ROW_W;
  localparam int ROW_ADDR_W = $clog2(ROWS);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  localparam int VERDICT_W = 3;
  localparam logic [VERDICT_W-1:0] VERDICT_RTT        = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_RTT     = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_WRONG_TYPE = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE  = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_OUT_OF_SEQ = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_CLEARED    = 3'd5;

  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_PACKET    = 2'd0,
    KIND_CLEAR     = 2'd1,
    KIND_BAD_TYPE  = 2'd2,
    KIND_DUPLICATE = 2'd3
  } kind_t;

  typedef struct packed {
    logic             operation;
    logic             type_ok;
    logic [SEQ_W-1:0] seq_num;
    logic [31:0]      send_time;
    logic [31:0]      arrival_time;
    logic             peer_ftt_valid;
    logic [31:0]      peer_ftt;
    logic [15:0]      size_bytes;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [SEQ_W-1:0] seq_num;
    logic [31:0]      arrival_time;
    logic             peer_ftt_valid;
    logic [31:0]      fwd;
    logic [32:0]      rtt;
    logic [15:0]      size_bytes;
  } qitem_t;

  typedef struct packed {
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [31:0]          forward_time;
    logic [32:0]          round_trip_time;
    logic [31:0]          received_count;
    logic [31:0]          lost_count;
    logic [31:0]          invalid_count;
    logic [SEQ_W-1:0]     highest_seq;
    logic [31:0]          rtt_sample_count;
    logic [47:0]          sum_forward_time;
    logic [47:0]          sum_round_trip_time;
    logic [47:0]          sum_bytes;
    logic [47:0]          sum_interval;
  } result_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX32 : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(logic [47:0] a, logic [32:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {16'd0, b};
    return s[48] ? MAX48 : s[47:0];
  endfunction

endpackage

>>> hw/rtl/rsts_ram.sv
// Generic single-write, single-read RAM with registered read-first output.
module rsts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rsts_front.sv
// Front end: accepts items, checks the seen bitmap and classifies each item.
module rsts_front import rsts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     drop,
  input  logic     push,
  input  in_item_t in_item,
  output logic     full,
  input  q_stat_t  q_stat,
  output logic     q_push,
  output qitem_t   q_item
);

  logic                  clearing;
  logic [ROW_ADDR_W-1:0] clr_addr;

  logic                  b_valid;
  in_item_t              b_item;
  logic [31:0]           b_fwd;

  logic                  fwd_valid;
  logic [ROW_ADDR_W-1:0] fwd_addr;
  logic [ROW_W-1:0]      fwd_data;

  logic                  accept;
  logic [SEQ_IDX_W-1:0]  in_idx;
  logic [SEQ_IDX_W-1:0]  b_idx;
  logic [ROW_ADDR_W-1:0] b_row;
  logic [ROW_BIT_W-1:0]  b_bit;
  logic [ROW_W-1:0]      ram_rdata;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_set;
  logic                  seen;
  logic                  mark;

  logic                  wr_en;
  logic [ROW_ADDR_W-1:0] wr_addr;
  logic [ROW_W-1:0]      wr_data;

  logic [Q_CNT_W:0]      in_flight;

  // Hold off new items while the bitmap is cleared or the queue cannot take everything already in flight.
  assign in_flight = {1'b0, q_stat.count} + {{Q_CNT_W{1'b0}}, b_valid};
  assign full      = clearing || (in_flight >= (Q_CNT_W + 1)'(Q_DEPTH));
  assign accept    = push && !full;

  assign in_idx = in_item.seq_num[SEQ_IDX_W-1:0];
  assign b_idx  = b_item.seq_num[SEQ_IDX_W-1:0];
  assign b_row  = b_idx[SEQ_IDX_W-1:ROW_BIT_W];
  assign b_bit  = b_idx[ROW_BIT_W-1:0];

  // Forward the row written in the same cycle as this item's read.
  assign row_cur = (fwd_valid && fwd_addr == b_row) ? fwd_data : ram_rdata;
  assign seen    = row_cur[b_bit];
  assign mark    = b_valid && !b_item.operation && b_item.type_ok;

  always_comb begin
    row_set        = row_cur;
    row_set[b_bit] = 1'b1;
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = mark;
      wr_addr = b_row;
      wr_data = row_set;
    end
  end

  rsts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (in_idx[SEQ_IDX_W-1:ROW_BIT_W]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      b_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing && clr_addr == ROW_ADDR_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr  <= clr_addr + 1'b1;
      b_valid   <= accept;
      fwd_valid <= wr_en;
    end
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
    if (accept) begin
      b_item <= in_item;
      b_fwd  <= (in_item.arrival_time > in_item.send_time) ?
                in_item.arrival_time - in_item.send_time : '0;
    end
  end

  always_comb begin
    q_push                = b_valid;
    q_item.seq_num        = b_item.seq_num;
    q_item.arrival_time   = b_item.arrival_time;
    q_item.peer_ftt_valid = b_item.peer_ftt_valid;
    q_item.fwd            = b_fwd;
    q_item.rtt            = b_item.peer_ftt_valid ?
                            {1'b0, b_fwd} + {1'b0, b_item.peer_ftt} : '0;
    q_item.size_bytes     = b_item.size_bytes;
    if (b_item.operation) begin
      q_item.kind = KIND_CLEAR;
    end else if (!b_item.type_ok) begin
      q_item.kind = KIND_BAD_TYPE;
    end else if (!drop && seen) begin
      q_item.kind = KIND_DUPLICATE;
    end else begin
      q_item.kind = KIND_PACKET;
    end
  end

endmodule

>>> hw/rtl/rsts_queue.sv
// Short queue of classified items between the front and back ends.
module rsts_queue import rsts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qitem_t  push_item,
  input  logic    pop,
  output qitem_t  head,
  output q_stat_t stat
);

  qitem_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;

  assign head       = entries[rd_ptr];
  assign stat.count = count;
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/rsts_back.sv
// Back end: sequence check against the last accepted number and statistics update.
module rsts_back import rsts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    drop,
  input  qitem_t  head,
  input  q_stat_t q_stat,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    pop
);

  logic [SEQ_W-1:0] last_seq,       last_seq_next;
  logic [31:0]      recv_cnt,       recv_cnt_next;
  logic [31:0]      loss_cnt,       loss_cnt_next;
  logic [31:0]      bad_cnt,        bad_cnt_next;
  logic [31:0]      rtt_cnt,        rtt_cnt_next;
  logic [47:0]      ftt_total,      ftt_total_next;
  logic [47:0]      rtt_total,      rtt_total_next;
  logic [47:0]      byte_total,     byte_total_next;
  logic [47:0]      interval_total, interval_total_next;
  logic [31:0]      last_arrival,   last_arrival_next;

  logic             go;
  logic [SEQ_W:0]   esn;
  logic [SEQ_W:0]   seq_w;
  logic [SEQ_W:0]   gap;
  logic [31:0]      dt;
  result_t          res_next;

  assign go    = !q_stat.empty && (!res_valid || pop);
  assign q_pop = go;
  assign esn   = {1'b0, last_seq} + (SEQ_W + 1)'(1);
  assign seq_w = {1'b0, head.seq_num};
  assign gap   = seq_w - esn;
  assign dt    = (head.arrival_time > last_arrival) ? head.arrival_time - last_arrival : '0;

  always_comb begin
    last_seq_next       = last_seq;
    recv_cnt_next       = recv_cnt;
    loss_cnt_next       = loss_cnt;
    bad_cnt_next        = bad_cnt;
    rtt_cnt_next        = rtt_cnt;
    ftt_total_next      = ftt_total;
    rtt_total_next      = rtt_total;
    byte_total_next     = byte_total;
    interval_total_next = interval_total;
    last_arrival_next   = last_arrival;
    res_next.verdict         = VERDICT_CLEARED;
    res_next.forward_time    = '0;
    res_next.round_trip_time = '0;
    unique case (head.kind)
      KIND_CLEAR: begin
        recv_cnt_next       = '0;
        loss_cnt_next       = '0;
        rtt_cnt_next        = '0;
        ftt_total_next      = '0;
        rtt_total_next      = '0;
        byte_total_next     = '0;
        interval_total_next = '0;
        res_next.verdict    = VERDICT_CLEARED;
      end
      KIND_BAD_TYPE: begin
        bad_cnt_next     = sat_add32(bad_cnt, 32'd1);
        res_next.verdict = VERDICT_WRONG_TYPE;
      end
      KIND_DUPLICATE: begin
        bad_cnt_next     = sat_add32(bad_cnt, 32'd1);
        res_next.verdict = VERDICT_DUPLICATE;
      end
      KIND_PACKET: begin
        if (drop && seq_w < esn) begin
          res_next.verdict = VERDICT_OUT_OF_SEQ;
        end else begin
          res_next.forward_time    = head.fwd;
          res_next.round_trip_time = head.rtt;
          if (head.peer_ftt_valid) begin
            rtt_total_next   = sat_add48(rtt_total, head.rtt);
            rtt_cnt_next     = sat_add32(rtt_cnt, 32'd1);
            res_next.verdict = VERDICT_RTT;
          end else begin
            res_next.verdict = VERDICT_NO_RTT;
          end
          ftt_total_next = sat_add48(ftt_total, {1'b0, head.fwd});
          recv_cnt_next  = sat_add32(recv_cnt, 32'd1);
          last_seq_next  = head.seq_num;
          // Count the skipped numbers as lost.
          if (drop && seq_w > esn) begin
            loss_cnt_next = sat_add32(loss_cnt, {16'd0, gap[SEQ_W-1:0]});
          end
          byte_total_next     = sat_add48(byte_total, {17'd0, head.size_bytes});
          interval_total_next = sat_add48(interval_total, {1'b0, dt});
          last_arrival_next   = head.arrival_time;
        end
      end
      default: begin
        res_next.verdict = VERDICT_CLEARED;
      end
    endcase
    res_next.received_count      = recv_cnt_next;
    res_next.lost_count          = loss_cnt_next;
    res_next.invalid_count       = bad_cnt_next;
    res_next.highest_seq         = last_seq_next;
    res_next.rtt_sample_count    = rtt_cnt_next;
    res_next.sum_forward_time    = ftt_total_next;
    res_next.sum_round_trip_time = rtt_total_next;
    res_next.sum_bytes           = byte_total_next;
    res_next.sum_interval        = interval_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid      <= 1'b0;
      last_seq       <= '0;
      recv_cnt       <= '0;
      loss_cnt       <= '0;
      bad_cnt        <= '0;
      rtt_cnt        <= '0;
      ftt_total      <= '0;
      rtt_total      <= '0;
      byte_total     <= '0;
      interval_total <= '0;
      last_arrival   <= '0;
    end else begin
      if (go) begin
        res_valid      <= 1'b1;
        last_seq       <= last_seq_next;
        recv_cnt       <= recv_cnt_next;
        loss_cnt       <= loss_cnt_next;
        bad_cnt        <= bad_cnt_next;
        rtt_cnt        <= rtt_cnt_next;
        ftt_total      <= ftt_total_next;
        rtt_total      <= rtt_total_next;
        byte_total     <= byte_total_next;
        interval_total <= interval_total_next;
        last_arrival   <= last_arrival_next;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
    if (go) begin
      res <= res_next;
    end
  end

endmodule

>>> hw/rtl/rx_sequence_tracker_stats.sv
// Top level of the receive sequence tracker with statistics.
// Takes one item per clock cycle while full is low and gives one result per item. The
// item passes the registered seen-bitmap read and the four-entry queue, from whose
// head the statistics update loads the result register. The bitmap
// is a RAM of 64-bit rows written back with the item's bit set in the cycle after the
// read; a write in the same cycle as the next read is forwarded, so items to the same
// row follow back to back. After reset the bitmap is cleared one row per cycle
// (1024 rows as built) while full stays high. Configuration writes
// are taken at any time, ready is always high; change the mode only while no item
// is in flight, since the front and back ends read it at different cycles.
module rx_sequence_tracker_stats import rsts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 operation,
  input  logic                 type_ok,
  input  logic [15:0]          seq_num,
  input  logic [31:0]          send_time,
  input  logic [31:0]          arrival_time,
  input  logic                 peer_ftt_valid,
  input  logic [31:0]          peer_ftt,
  input  logic [15:0]          size_bytes,
  output logic                 empty,
  input  logic                 pop,
  output logic [VERDICT_W-1:0] verdict,
  output logic [31:0]          forward_time,
  output logic [32:0]          round_trip_time,
  output logic [31:0]          received_count,
  output logic [31:0]          lost_count,
  output logic [31:0]          invalid_count,
  output logic [15:0]          highest_seq,
  output logic [31:0]          rtt_sample_count,
  output logic [47:0]          sum_forward_time,
  output logic [47:0]          sum_round_trip_time,
  output logic [47:0]          sum_bytes,
  output logic [47:0]          sum_interval,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic     drop;
  in_item_t in_item;
  logic     q_push;
  qitem_t   q_item;
  logic     q_pop;
  qitem_t   q_head;
  q_stat_t  q_stat;
  logic     res_valid;
  result_t  res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drop <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      drop <= cfg_data;
    end
  end

  assign in_item.operation      = operation;
  assign in_item.type_ok        = type_ok;
  assign in_item.seq_num        = seq_num;
  assign in_item.send_time      = send_time;
  assign in_item.arrival_time   = arrival_time;
  assign in_item.peer_ftt_valid = peer_ftt_valid;
  assign in_item.peer_ftt       = peer_ftt;
  assign in_item.size_bytes     = size_bytes;

  rsts_front u_front (
    .clk     (clk),
    .rst     (rst),
    .drop    (drop),
    .push    (push),
    .in_item (in_item),
    .full    (full),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  rsts_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  rsts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .drop      (drop),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .pop       (pop)
  );

  assign empty               = !res_valid;
  assign verdict             = res.verdict;
  assign forward_time        = res.forward_time;
  assign round_trip_time     = res.round_trip_time;
  assign received_count      = res.received_count;
  assign lost_count          = res.lost_count;
  assign invalid_count       = res.invalid_count;
  assign highest_seq         = res.highest_seq;
  assign rtt_sample_count    = res.rtt_sample_count;
  assign sum_forward_time    = res.sum_forward_time;
  assign sum_round_trip_time = res.sum_round_trip_time;
  assign sum_bytes           = res.sum_bytes;
  assign sum_interval        = res.sum_interval;

  // Bitmap clearing must block input right after reset.
  assert property (@(posedge clk) rst |=> full)
    else $error("input open during bitmap clear");

  assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> q_stat.count < Q_CNT_W'(Q_DEPTH))
    else $error("classified item queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty item queue");

  assert property (@(posedge clk) disable iff (rst)
    !empty && verdict != VERDICT_RTT && verdict != VERDICT_NO_RTT
      |-> forward_time == '0 && round_trip_time == '0)
    else $error("times reported for an item not accepted");

endmodule
